// ===== src/scsf_pkg.sv =====
// Shared types and constants for the serial camera snapshot fetcher.
package scsf_pkg;

    // Input beat commands
    localparam logic [1:0] CMD_START   = 2'd0;
    localparam logic [1:0] CMD_BYTE    = 2'd1;
    localparam logic [1:0] CMD_TIMEOUT = 2'd2;

    // Configuration register indexes
    localparam logic [2:0] CFG_RES   = 3'd0;
    localparam logic [2:0] CFG_UNC   = 3'd1;
    localparam logic [2:0] CFG_PTYPE = 3'd2;
    localparam logic [2:0] CFG_PSIZE = 3'd3;
    localparam logic [2:0] CFG_RETRY = 3'd4;

    // Phase codes
    localparam logic [2:0] PH_IDLE   = 3'd0;
    localparam logic [2:0] PH_SETUP0 = 3'd1;
    localparam logic [2:0] PH_SIZE   = 3'd6;
    localparam logic [2:0] PH_PACK   = 3'd7;

    // Final status codes
    localparam logic [1:0] ST_OK      = 2'd0;
    localparam logic [1:0] ST_NO_SIZE = 2'd1;
    localparam logic [1:0] ST_MISSED  = 2'd2;

    // Protocol bytes
    localparam logic [7:0] B_SYNC = 8'haa;
    localparam logic [7:0] B_DATA = 8'h0a;
    localparam logic [7:0] B_ACK  = 8'h0e;
    localparam logic [7:0] B_END  = 8'hf0;

    typedef struct packed {
        logic [1:0] cmd;
        logic [7:0] rx_byte;
    } t_in_beat;

    typedef struct packed {
        logic        tx_valid;
        logic [7:0]  tx_byte;
        logic        payload_valid;
        logic [7:0]  payload_byte;
        logic        package_end;
        logic        package_good;
        logic [15:0] package_number;
        logic        done_res;
        logic [1:0]  status;
        logic [23:0] picture_bytes;
        logic        last;
    } t_out_beat;

    typedef struct packed {
        logic [2:0] resolution_code;
        logic       uncompressed_mode;
        logic [7:0] picture_type;
        logic [9:0] package_size;
        logic [3:0] retry_limit;
    } t_cfg;

    typedef logic [5:0][7:0] t_cmd6;

    // Results caused by one input beat: optional head, six-byte command, final status
    typedef struct packed {
        logic        head_en;
        logic        head_pv;
        logic [7:0]  head_pb;
        logic        head_end;
        logic        head_good;
        logic [15:0] head_num;
        logic        tx_en;
        t_cmd6       tx_bytes;
        logic [15:0] tx_num;
        logic        fin_en;
        logic [1:0]  fin_status;
        logic [23:0] pic;
    } t_burst;

    // Set-up command k, byte 0 first
    function automatic t_cmd6 setup_cmd(input logic [2:0] k, input t_cfg cfg,
                                        input logic [9:0] size);
        t_cmd6 c;
        c[0] = B_SYNC;
        case (k)
            3'd0: begin
                c[1] = 8'h01; c[2] = 8'h00; c[3] = 8'h07; c[4] = 8'h07;
                c[5] = {5'd0, cfg.resolution_code};
            end
            3'd1: begin
                c[1] = 8'h07; c[2] = 8'h00; c[3] = 8'h01; c[4] = 8'h00; c[5] = 8'h00;
            end
            3'd2: begin
                c[1] = 8'h06; c[2] = 8'h08; c[3] = size[7:0]; c[4] = {6'd0, size[9:8]};
                c[5] = 8'h00;
            end
            3'd3: begin
                c[1] = 8'h05; c[2] = {7'd0, cfg.uncompressed_mode}; c[3] = 8'h00;
                c[4] = 8'h00; c[5] = 8'h00;
            end
            default: begin
                c[1] = 8'h04; c[2] = cfg.picture_type; c[3] = 8'h00; c[4] = 8'h00;
                c[5] = 8'h00;
            end
        endcase
        return c;
    endfunction

    function automatic t_cmd6 request_cmd(input logic [7:0] lo, input logic [7:0] hi);
        t_cmd6 c;
        c[0] = B_SYNC; c[1] = B_ACK; c[2] = 8'h00; c[3] = 8'h00; c[4] = lo; c[5] = hi;
        return c;
    endfunction

endpackage

// ===== src/scsf_engine.sv =====
// Download state machine: updates state per input beat and builds its result burst.
module scsf_engine import scsf_pkg::*; #(
    parameter int MAX_PACKAGE = 512
) (
    input  logic     i_clk,
    input  logic     i_rst_n,
    input  logic     i_take,
    input  t_in_beat i_beat,
    input  t_cfg     i_cfg,
    output t_burst   o_burst,
    output logic     o_any
);
    localparam logic [9:0] MaxSz = 10'(MAX_PACKAGE);
    localparam logic [9:0] MinSz = 10'd8;

    logic [2:0]  r_phase, n_phase;
    logic [9:0]  r_rx, n_rx;
    logic [7:0]  r_sum, n_sum;
    logic [7:0]  r_lag0, n_lag0, r_lag1, n_lag1;
    logic [23:0] r_pic, n_pic;
    logic [15:0] r_idx, n_idx;
    logic [31:0] r_pay, n_pay, r_rec, n_rec;
    logic [3:0]  r_ret, n_ret;
    logic [7:0]  r_reply [6];
    logic        reply_we;
    logic [2:0]  reply_wa;

    logic [9:0]  eff_size;
    logic [3:0]  eff_lim;
    logic        do_close, good;
    logic [9:0]  cl_n, cnt;
    logic [7:0]  cl_sum, cl_lag;
    logic [31:0] pay_new, rec_new, expect_total;
    logic [15:0] idx_new;
    logic [2:0]  k;
    t_burst      d;

    always_comb begin
        eff_size = i_cfg.package_size;
        if (eff_size < MinSz) eff_size = MinSz;
        if (eff_size > MaxSz) eff_size = MaxSz;
        eff_lim = (i_cfg.retry_limit == 4'd0) ? 4'd1 : i_cfg.retry_limit;
    end

    // Next state and burst for the accepted beat
    always_comb begin
        n_phase = r_phase; n_rx = r_rx; n_sum = r_sum; n_lag0 = r_lag0; n_lag1 = r_lag1;
        n_pic = r_pic; n_idx = r_idx; n_pay = r_pay; n_rec = r_rec; n_ret = r_ret;
        reply_we = 1'b0; reply_wa = r_rx[2:0];
        do_close = 1'b0; cl_n = r_rx; cl_sum = r_sum; cl_lag = r_lag1;
        good = 1'b0; pay_new = '0; rec_new = '0; idx_new = '0; expect_total = '0;
        k = r_phase - PH_SETUP0;
        cnt = r_rx + 10'd1;
        d = '0;
        case (i_beat.cmd)
            CMD_START: begin
                n_rx = '0; n_sum = '0; n_lag0 = '0; n_lag1 = '0;
                n_pic = '0; n_idx = '0; n_pay = '0; n_rec = '0; n_ret = eff_lim;
                n_phase = PH_SETUP0;
                d.tx_en = 1'b1; d.tx_bytes = setup_cmd(3'd0, i_cfg, eff_size);
            end
            CMD_BYTE: begin
                if (r_phase >= PH_SETUP0 && r_phase <= PH_SIZE) begin
                    reply_we = (r_rx < 10'd6);
                    n_rx = cnt;
                    if (cnt >= 10'd6) begin
                        n_rx = '0;
                        if (r_phase == PH_SIZE) begin
                            if (r_reply[0] == B_SYNC && r_reply[1] == B_DATA) begin
                                n_pic = {i_beat.rx_byte, r_reply[4], r_reply[3]};
                                n_phase = PH_PACK;
                                n_sum = '0; n_lag0 = '0; n_lag1 = '0;
                                d.tx_en = 1'b1;
                                d.tx_bytes = request_cmd(r_idx[7:0], r_idx[15:8]);
                            end else begin
                                d.fin_en = 1'b1; d.fin_status = ST_NO_SIZE;
                                n_phase = PH_IDLE;
                            end
                        end else if (k >= 3'd4) begin
                            n_phase = PH_SIZE;
                        end else begin
                            n_phase = r_phase + 3'd1;
                            d.tx_en = 1'b1;
                            d.tx_bytes = setup_cmd(k + 3'd1, i_cfg, eff_size);
                        end
                    end
                end else if (r_phase == PH_PACK) begin
                    // payload leaves two bytes behind arrival
                    if (r_rx >= 10'd2) begin
                        n_sum = r_sum + r_lag1;
                        if (r_rx >= 10'd6) begin
                            d.head_en = 1'b1; d.head_pv = 1'b1; d.head_pb = r_lag1;
                            d.head_num = r_idx;
                        end
                    end
                    n_lag1 = r_lag0; n_lag0 = i_beat.rx_byte; n_rx = cnt;
                    if (cnt >= eff_size) begin
                        do_close = 1'b1; cl_n = cnt; cl_sum = n_sum; cl_lag = r_lag0;
                    end
                end
            end
            CMD_TIMEOUT: begin
                if (r_phase >= PH_SETUP0 && r_phase < PH_SIZE) begin
                    n_rx = '0;
                    if (k >= 3'd4) begin
                        n_phase = PH_SIZE;
                    end else begin
                        n_phase = r_phase + 3'd1;
                        d.tx_en = 1'b1;
                        d.tx_bytes = setup_cmd(k + 3'd1, i_cfg, eff_size);
                    end
                end else if (r_phase == PH_SIZE) begin
                    n_rx = '0; n_phase = PH_IDLE;
                    d.fin_en = 1'b1; d.fin_status = ST_NO_SIZE;
                end else if (r_phase == PH_PACK) begin
                    do_close = 1'b1;
                end
            end
            default: begin
            end
        endcase

        // Package close: verify, then request next, end, retry the same package, or give up
        if (do_close) begin
            good = (cl_n >= 10'd6) && (cl_n <= MaxSz) && (cl_sum == cl_lag);
            d.head_en = 1'b1; d.head_end = 1'b1; d.head_good = good; d.head_num = r_idx;
            n_rx = '0; n_sum = '0; n_lag0 = '0; n_lag1 = '0;
            if (good) begin
                idx_new = r_idx + 16'd1;
                rec_new = r_rec + 32'(cl_n);
                pay_new = r_pay + 32'(eff_size - 10'd6);
                expect_total = 32'(r_pic) + {14'd0, idx_new, 2'b00} + {15'd0, idx_new, 1'b0};
                n_idx = idx_new; n_rec = rec_new; n_pay = pay_new; n_ret = eff_lim;
                d.tx_en = 1'b1;
                if (pay_new >= 32'(r_pic)) begin
                    d.tx_bytes = request_cmd(B_END, B_END);
                    d.fin_en = 1'b1;
                    d.fin_status = (rec_new == expect_total) ? ST_OK : ST_MISSED;
                    n_phase = PH_IDLE;
                end else begin
                    d.tx_bytes = request_cmd(idx_new[7:0], idx_new[15:8]);
                end
            end else begin
                n_ret = r_ret - 4'd1;
                if (n_ret == 4'd0) begin
                    d.fin_en = 1'b1; d.fin_status = ST_MISSED; n_phase = PH_IDLE;
                end else begin
                    d.tx_en = 1'b1;
                    d.tx_bytes = request_cmd(r_idx[7:0], r_idx[15:8]);
                end
            end
        end
        d.tx_num = n_idx;
        d.pic = n_pic;
    end

    assign o_burst = d;
    assign o_any   = d.head_en | d.tx_en | d.fin_en;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase <= PH_IDLE; r_rx <= '0; r_sum <= '0; r_lag0 <= '0; r_lag1 <= '0;
            r_pic <= '0; r_idx <= '0; r_pay <= '0; r_rec <= '0; r_ret <= 4'd5;
        end else if (i_take) begin
            r_phase <= n_phase; r_rx <= n_rx; r_sum <= n_sum; r_lag0 <= n_lag0;
            r_lag1 <= n_lag1; r_pic <= n_pic; r_idx <= n_idx; r_pay <= n_pay;
            r_rec <= n_rec; r_ret <= n_ret;
        end
    end

    // Reply capture
    always_ff @(posedge i_clk) begin
        if (i_take && reply_we) r_reply[reply_wa] <= i_beat.rx_byte;
    end
endmodule

// ===== src/scsf_serializer.sv =====
// Holds one result burst and hands it out one beat per cycle while i_out_ready is high.
module scsf_serializer import scsf_pkg::*; (
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_load,
    input  t_burst    i_burst,
    input  logic      i_out_ready,
    output logic      o_out_valid,
    output t_out_beat o_out_data,
    output logic      o_free
);
    t_burst     r_b;
    logic       r_busy;
    logic [2:0] r_pos;
    logic [2:0] slot;
    logic [3:0] total;
    logic       is_last, take;
    t_out_beat  o;

    always_comb begin
        slot  = r_pos - {2'd0, r_b.head_en};
        total = {3'd0, r_b.head_en} + (r_b.tx_en ? 4'd6 : 4'd0) + {3'd0, r_b.fin_en};
        is_last = ({1'b0, r_pos} + 4'd1) == total;
        o = '0;
        o.picture_bytes = r_b.pic;
        if (r_b.head_en && r_pos == 3'd0) begin
            o.payload_valid = r_b.head_pv; o.payload_byte = r_b.head_pb;
            o.package_end = r_b.head_end; o.package_good = r_b.head_good;
            o.package_number = r_b.head_num;
        end else if (r_b.tx_en && slot < 3'd6) begin
            o.tx_valid = 1'b1; o.tx_byte = r_b.tx_bytes[slot];
            o.package_number = r_b.tx_num;
        end else begin
            o.done_res = 1'b1; o.status = r_b.fin_status; o.package_number = r_b.tx_num;
        end
        o.last = is_last;
    end

    assign o_out_valid = r_busy;
    assign o_out_data  = o;
    assign take        = r_busy && i_out_ready;
    assign o_free      = !r_busy || (take && is_last);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0; r_pos <= '0;
        end else if (i_load) begin
            r_busy <= 1'b1; r_pos <= '0;
        end else if (take) begin
            r_busy <= !is_last; r_pos <= r_pos + 3'd1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_load) r_b <= i_burst;
    end
endmodule

// ===== src/serial_camera_snapshot_fetcher_core.sv =====
// Top level: configuration registers, download engine and result serializer.
// Latency: results of a beat start the cycle after it is accepted.
// Throughput: one result per cycle while i_out_ready is high; a beat makes 0 to 8 results,
//   so an input beat is taken only once the serializer is free or hands out its last result.
// Reset: synchronous active low; idle phase, counters cleared, config to defaults.
module serial_camera_snapshot_fetcher_core import scsf_pkg::*; #(
    parameter int MAX_PACKAGE = 512
) (
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_in_valid,
    output logic      o_in_ready,
    input  t_in_beat  i_in_data,
    output logic      o_out_valid,
    input  logic      i_out_ready,
    output t_out_beat o_out_data,
    input  logic      i_cfg_valid,
    output logic      o_cfg_ready,
    input  logic [2:0] i_cfg_index,
    input  logic [9:0] i_cfg_data
);
    t_cfg   r_cfg;
    t_burst burst;
    logic   any, free, take;

    assign o_cfg_ready = 1'b1;

    // Configuration writes
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.resolution_code   <= 3'd7;
            r_cfg.uncompressed_mode <= 1'b0;
            r_cfg.picture_type      <= 8'd1;
            r_cfg.package_size      <= 10'd512;
            r_cfg.retry_limit       <= 4'd5;
        end else if (i_cfg_valid) begin
            case (i_cfg_index)
                CFG_RES:   r_cfg.resolution_code   <= i_cfg_data[2:0];
                CFG_UNC:   r_cfg.uncompressed_mode <= i_cfg_data[0];
                CFG_PTYPE: r_cfg.picture_type      <= i_cfg_data[7:0];
                CFG_PSIZE: r_cfg.package_size      <= i_cfg_data;
                CFG_RETRY: r_cfg.retry_limit       <= i_cfg_data[3:0];
                default: begin
                end
            endcase
        end
    end

    assign o_in_ready = free;
    assign take       = i_in_valid && free;

    scsf_engine #(.MAX_PACKAGE(MAX_PACKAGE)) u_engine (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_take(take), .i_beat(i_in_data),
        .i_cfg(r_cfg), .o_burst(burst), .o_any(any)
    );

    scsf_serializer u_ser (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_load(take && any), .i_burst(burst),
        .i_out_ready(i_out_ready), .o_out_valid(o_out_valid), .o_out_data(o_out_data),
        .o_free(free)
    );

    // Final status always closes a burst
    a_done_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_out_data.done_res |-> o_out_data.last)
        else $error("done result not last");

    // A beat never carries both a command byte and a payload byte
    a_one_kind: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> !(o_out_data.tx_valid && o_out_data.payload_valid))
        else $error("mixed result beat");

    // Input stalls only behind pending results
    a_stall: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !o_in_ready |-> o_out_valid)
        else $error("input stalled with no pending results");
endmodule
